// ===== rtl/sse_pkg.sv =====
// Shared constants and types for the selection sort engine.
// No dependencies; imported by sse_store and selection_sort_engine.
`default_nettype none

package sse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_SCAN    = 3'b010,
        S_EMIT    = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sse_store.sv =====
// Element store of the selection sort engine: one write port, one read port
// with registered read data. Depends on sse_pkg.
`default_nettype none

module sse_store
    import sse_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_wr_en,
    input  t_idx  i_wr_addr,
    input  t_data i_wr_data,
    input  wire   i_rd_en,
    input  t_idx  i_rd_addr,
    output t_data o_rd_data
);

    t_data r_mem [MAX_ELEMENTS];
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/selection_sort_engine.sv =====
// Selection sort engine: collects signed words, sorts them with one comparator
// over a two-port store, emits them in order. Depends on sse_pkg, sse_store.
//
// Use:
//   Input channel (i_in_valid / o_in_stall): one word per accepted cycle,
//   i_value plus i_last. Words go into a 64-entry store; words beyond that are
//   dropped and flag the whole set. A word with i_last starts the sort.
//   Output channel (o_out_valid / i_out_stall): the sorted words, o_end_of_set
//   on the final one, o_dropped on all of a set that lost words.
//   Config channel (i_cfg_valid / o_cfg_ready): bit 0 selects descending order.
//   Always ready; write only while the block is idle.
// Operation:
//   For each position the remaining words are read from the store and compared,
//   then the winner is swapped into place and emitted; the sort is bounded by
//   the one store read port feeding the single comparator. o_in_stall is high
//   from the cycle after the last word until the final result is loaded.
// Reset clears the fill count, the overflow flag, the direction (ascending)
// and the output valid flag, and returns to collecting. A stalled receiver holds
// the output register, and the sequencer waits before loading the next result.
`default_nettype none

module selection_sort_engine
    import sse_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_data i_value,
    input  wire   i_last,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    output t_data o_sorted_value,
    output logic  o_end_of_set,
    output logic  o_dropped,
    input  wire   i_cfg_valid,
    output logic  o_cfg_ready,
    input  wire   i_cfg_data
);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_overflow, n_overflow;
    logic   r_desc, n_desc;
    t_idx   r_pos, n_pos;
    t_cnt   r_scan, n_scan;
    logic   r_dv, n_dv;
    t_idx   r_didx, n_didx;
    t_idx   r_pick, n_pick;
    t_data  r_best, n_best;
    t_data  r_pos_val, n_pos_val;
    logic   r_out_valid, n_out_valid;
    t_data  r_out_value, n_out_value;
    logic   r_out_end, n_out_end;
    logic   r_out_drop, n_out_drop;

    logic   wr_en, rd_en;
    t_idx   wr_addr;
    t_data  wr_data;
    t_data  rd_data;
    t_cnt   last_idx;
    logic   goes_first, pos_is_last, out_free;

    sse_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign last_idx    = r_count - t_cnt'(1);
    assign pos_is_last = ({1'b0, r_pos} == last_idx);
    assign goes_first  = r_desc ? (rd_data > r_best) : (rd_data < r_best);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_desc      = r_desc;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_pick      = r_pick;
        n_best      = r_best;
        n_pos_val   = r_pos_val;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_drop  = r_out_drop;
        wr_en       = 1'b0;
        wr_addr     = r_count[IDX_W-1:0];
        wr_data     = i_value;
        rd_en       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_desc = i_cfg_data;
        end

        case (r_state)
            S_COLLECT: begin
                if (i_in_valid) begin
                    if (r_count < t_cnt'(MAX_ELEMENTS)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + t_cnt'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last) begin
                        n_pos   = '0;
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_dv = 1'b0;
                // issue the next read while the previous word is compared
                if (r_scan < r_count) begin
                    rd_en  = 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_scan[IDX_W-1:0];
                    n_scan = r_scan + t_cnt'(1);
                end
                if (r_dv) begin
                    if (r_didx == r_pos) begin
                        n_best    = rd_data;
                        n_pick    = r_didx;
                        n_pos_val = rd_data;
                    end else if (goes_first) begin
                        n_best = rd_data;
                        n_pick = r_didx;
                    end
                    if ({1'b0, r_didx} == last_idx) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    // swap: the winner goes out, the displaced word moves to its slot
                    wr_en       = 1'b1;
                    wr_addr     = r_pick;
                    wr_data     = r_pos_val;
                    n_out_valid = 1'b1;
                    n_out_value = r_best;
                    n_out_end   = pos_is_last;
                    n_out_drop  = r_overflow;
                    if (pos_is_last) begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_state    = S_COLLECT;
                    end else begin
                        n_pos   = r_pos + t_idx'(1);
                        n_scan  = {1'b0, r_pos} + t_cnt'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_desc      <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_desc      <= n_desc;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_scan      <= n_scan;
        r_didx      <= n_didx;
        r_pick      <= n_pick;
        r_best      <= n_best;
        r_pos_val   <= n_pos_val;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_drop  <= n_out_drop;
    end

    assign o_in_stall     = (r_state != S_COLLECT);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_end_of_set   = r_out_end;
    assign o_dropped      = r_out_drop;
    assign o_cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/sse_checker.sv =====
// Port-level checks for the selection sort engine, bound to the top level.
// Depends on selection_sort_engine's port list only.
`default_nettype none

module sse_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire o_in_stall,
    input wire i_last,
    input wire o_out_valid,
    input wire i_out_stall,
    input wire o_cfg_ready
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // the word closing a set starts the sort, so input stalls next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last |=> o_in_stall)
        else $error("input not stalled after end of set");

    // reset leaves the block collecting with an empty output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind selection_sort_engine sse_checker u_sse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_last      (i_last),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
